FILE: hdl/source_tokenizer_core_assert.svh
// Assertion macros for the source tokenizer checker.
// Depends on a clock named clk and an active-high reset named rst in the using scope.
`ifndef SOURCE_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TOKENIZER_CORE_ASSERT_SVH

// Checked on every edge while the block is out of reset.
`define STOK_ASSERT_ON(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("tokenizer port check failed");

// Checked on every edge, reset included.
`define STOK_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("tokenizer reset check failed");

`endif

FILE: hdl/stok_pkg.sv
// Shared types, token kind codes and keyword tables for the source tokenizer.
// No dependencies.
package stok_pkg;

  localparam int DEF_POSITION_BITS = 32;
  localparam int DEF_LENGTH_BITS = 16;

  localparam int KIND_BITS = 6;
  localparam int OFFSET_BITS = 32;
  localparam int TLEN_BITS = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_BITS-1:0] KIND_END      = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_INT      = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_STRING   = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_PRINT    = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_FUNC     = 6'd5;
  localparam logic [KIND_BITS-1:0] KIND_RETURN   = 6'd6;
  localparam logic [KIND_BITS-1:0] KIND_IF       = 6'd7;
  localparam logic [KIND_BITS-1:0] KIND_ELSE     = 6'd8;
  localparam logic [KIND_BITS-1:0] KIND_WHILE    = 6'd9;
  localparam logic [KIND_BITS-1:0] KIND_BREAK    = 6'd10;
  localparam logic [KIND_BITS-1:0] KIND_CONTINUE = 6'd11;
  localparam logic [KIND_BITS-1:0] KIND_PLUS     = 6'd12;
  localparam logic [KIND_BITS-1:0] KIND_MINUS    = 6'd13;
  localparam logic [KIND_BITS-1:0] KIND_STAR     = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_SLASH    = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_PERCENT  = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_EQEQ     = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_SEMI     = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 6'd23;
  localparam logic [KIND_BITS-1:0] KIND_COMMA    = 6'd24;
  localparam logic [KIND_BITS-1:0] KIND_LE       = 6'd25;
  localparam logic [KIND_BITS-1:0] KIND_LT       = 6'd26;
  localparam logic [KIND_BITS-1:0] KIND_GE       = 6'd27;
  localparam logic [KIND_BITS-1:0] KIND_GT       = 6'd28;
  localparam logic [KIND_BITS-1:0] KIND_NE       = 6'd29;
  localparam logic [KIND_BITS-1:0] KIND_BANG     = 6'd30;
  localparam logic [KIND_BITS-1:0] KIND_ANDAND   = 6'd31;
  localparam logic [KIND_BITS-1:0] KIND_OROR     = 6'd32;

  localparam int KW_COUNT = 8;

  // Keyword text packed with the first character in the low byte.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0074_6e69_7270,
    64'h0000_0000_636e_7566,
    64'h0000_6e72_7574_6572,
    64'h0000_0000_0000_6669,
    64'h0000_0000_6573_6c65,
    64'h0000_0065_6c69_6877,
    64'h0000_006b_6165_7262,
    64'h6575_6e69_746e_6f63
  };
  localparam int KW_LEN [KW_COUNT] = '{5, 4, 6, 2, 4, 5, 5, 8};
  localparam logic [KIND_BITS-1:0] KW_KIND [KW_COUNT] = '{
    KIND_PRINT, KIND_FUNC, KIND_RETURN, KIND_IF,
    KIND_ELSE, KIND_WHILE, KIND_BREAK, KIND_CONTINUE
  };

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [TLEN_BITS-1:0]   text_length;
  } tok_t;

  // All results caused by one byte; second is used only when pair is set.
  typedef struct packed {
    logic pair;
    tok_t first;
    tok_t second;
  } entry_t;

endpackage

FILE: hdl/stok_front.sv
// Front end of the source tokenizer: lexer mode register and per-byte classification.
// Depends on stok_pkg.
module stok_front #(
  parameter int POSITION_BITS = stok_pkg::DEF_POSITION_BITS,
  parameter int LENGTH_BITS = stok_pkg::DEF_LENGTH_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      ch,
  input  logic            accept,
  output stok_pkg::entry_t entry,
  output logic            entry_valid
);
  import stok_pkg::*;

  localparam int PEXT = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;
  localparam int LEXT = (LENGTH_BITS > TLEN_BITS) ? LENGTH_BITS : TLEN_BITS;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_INT, M_STR, M_ESC,
    M_IDENT, M_EQ, M_LT, M_GT, M_BANG, M_AMP, M_BAR
  } mode_t;

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] token_start, token_start_next;
  logic [LENGTH_BITS-1:0]   token_length, token_length_next;
  logic [63:0]              word_prefix, word_prefix_next;

  logic [LENGTH_BITS-1:0]   len_inc;
  logic [KIND_BITS-1:0]     word_kind;
  logic                     relex;
  logic                     pair_mode;
  logic [7:0]               want;
  logic [KIND_BITS-1:0]     two_kind, one_kind;
  logic                     pend_valid;
  logic [KIND_BITS-1:0]     pend_kind;
  logic [LENGTH_BITS-1:0]   pend_len;
  logic                     idle_valid;
  logic [KIND_BITS-1:0]     idle_kind;
  logic                     idle_len;
  logic [PEXT-1:0]          start_ext, pos_ext;
  logic [LEXT-1:0]          pend_len_ext;
  tok_t                     pend_tok, idle_tok;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  assign len_inc = (token_length == LEN_MAX) ? token_length : token_length + 1'b1;

  always_comb begin
    word_kind = KIND_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (token_length == LENGTH_BITS'(KW_LEN[i]) && word_prefix == KW_TEXT[i]) begin
        word_kind = KW_KIND[i];
      end
    end
  end

  always_comb begin
    mode_next = mode;
    token_start_next = token_start;
    token_length_next = token_length;
    word_prefix_next = word_prefix;
    relex = 1'b0;
    pair_mode = 1'b0;
    want = "=";
    two_kind = KIND_END;
    one_kind = KIND_END;
    pend_valid = 1'b0;
    pend_kind = KIND_END;
    pend_len = token_length;
    idle_valid = 1'b0;
    idle_kind = KIND_END;
    idle_len = 1'b0;

    case (mode)
      M_SLASH: begin
        if (ch == "/") begin
          mode_next = M_LINE;
        end else if (ch == "*") begin
          mode_next = M_BLOCK;
        end else begin
          pend_valid = 1'b1;
          pend_kind = KIND_SLASH;
          pend_len = LENGTH_BITS'(1);
          relex = 1'b1;
        end
      end
      M_LINE: begin
        if (ch == 8'd0) begin
          relex = 1'b1;
        end else if (ch == 8'd10) begin
          mode_next = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (ch == 8'd0) begin
          relex = 1'b1;
        end else if (ch == "*") begin
          mode_next = M_BSTAR;
        end
      end
      M_BSTAR: begin
        if (ch == 8'd0) begin
          relex = 1'b1;
        end else if (ch == "/") begin
          mode_next = M_IDLE;
        end else if (ch != "*") begin
          mode_next = M_BLOCK;
        end
      end
      M_INT: begin
        if (is_digit(ch)) begin
          token_length_next = len_inc;
        end else begin
          pend_valid = 1'b1;
          pend_kind = KIND_INT;
          relex = 1'b1;
        end
      end
      M_STR, M_ESC: begin
        if (ch == 8'd0) begin
          pend_valid = 1'b1;
          pend_kind = KIND_STRING;
          relex = 1'b1;
        end else if (mode == M_ESC) begin
          token_length_next = len_inc;
          mode_next = M_STR;
        end else if (ch == "\"") begin
          pend_valid = 1'b1;
          pend_kind = KIND_STRING;
          mode_next = M_IDLE;
        end else begin
          if (ch == "\\") begin
            mode_next = M_ESC;
          end
          token_length_next = len_inc;
        end
      end
      M_IDENT: begin
        if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
          for (int j = 0; j < 8; j++) begin
            if (token_length == LENGTH_BITS'(j)) begin
              word_prefix_next[8*j +: 8] = ch;
            end
          end
          token_length_next = len_inc;
        end else begin
          pend_valid = 1'b1;
          pend_kind = word_kind;
          relex = 1'b1;
        end
      end
      M_EQ: begin
        pair_mode = 1'b1;
        two_kind = KIND_EQEQ;
        one_kind = KIND_ASSIGN;
      end
      M_LT: begin
        pair_mode = 1'b1;
        two_kind = KIND_LE;
        one_kind = KIND_LT;
      end
      M_GT: begin
        pair_mode = 1'b1;
        two_kind = KIND_GE;
        one_kind = KIND_GT;
      end
      M_BANG: begin
        pair_mode = 1'b1;
        two_kind = KIND_NE;
        one_kind = KIND_BANG;
      end
      M_AMP: begin
        pair_mode = 1'b1;
        want = "&";
        two_kind = KIND_ANDAND;
      end
      M_BAR: begin
        pair_mode = 1'b1;
        want = "|";
        two_kind = KIND_OROR;
      end
      default: begin
        relex = 1'b1;
      end
    endcase

    if (pair_mode) begin
      pend_valid = 1'b1;
      if (ch == want) begin
        pend_kind = two_kind;
        pend_len = LENGTH_BITS'(2);
        mode_next = M_IDLE;
      end else begin
        pend_kind = one_kind;
        pend_len = (one_kind == KIND_END) ? '0 : LENGTH_BITS'(1);
        relex = 1'b1;
      end
    end

    if (relex) begin
      mode_next = M_IDLE;
      if (ch == 8'd0) begin
        idle_valid = 1'b1;
      end else if (is_space(ch)) begin
        idle_valid = 1'b0;
      end else if (is_digit(ch)) begin
        mode_next = M_INT;
        token_start_next = position;
        token_length_next = LENGTH_BITS'(1);
      end else if (is_alpha(ch) || ch == "_") begin
        mode_next = M_IDENT;
        token_start_next = position;
        token_length_next = LENGTH_BITS'(1);
        word_prefix_next = {56'd0, ch};
      end else if (ch == "\"") begin
        mode_next = M_STR;
        token_start_next = position + 1'b1;
        token_length_next = '0;
      end else begin
        case (ch)
          "/", "=", "<", ">", "!", "&", "|": begin
            token_start_next = position;
            token_length_next = LENGTH_BITS'(1);
            case (ch)
              "/": mode_next = M_SLASH;
              "=": mode_next = M_EQ;
              "<": mode_next = M_LT;
              ">": mode_next = M_GT;
              "!": mode_next = M_BANG;
              "&": mode_next = M_AMP;
              default: mode_next = M_BAR;
            endcase
          end
          "+": begin idle_valid = 1'b1; idle_kind = KIND_PLUS;    idle_len = 1'b1; end
          "-": begin idle_valid = 1'b1; idle_kind = KIND_MINUS;   idle_len = 1'b1; end
          "*": begin idle_valid = 1'b1; idle_kind = KIND_STAR;    idle_len = 1'b1; end
          "%": begin idle_valid = 1'b1; idle_kind = KIND_PERCENT; idle_len = 1'b1; end
          ";": begin idle_valid = 1'b1; idle_kind = KIND_SEMI;    idle_len = 1'b1; end
          "(": begin idle_valid = 1'b1; idle_kind = KIND_LPAREN;  idle_len = 1'b1; end
          ")": begin idle_valid = 1'b1; idle_kind = KIND_RPAREN;  idle_len = 1'b1; end
          "{": begin idle_valid = 1'b1; idle_kind = KIND_LBRACE;  idle_len = 1'b1; end
          "}": begin idle_valid = 1'b1; idle_kind = KIND_RBRACE;  idle_len = 1'b1; end
          ",": begin idle_valid = 1'b1; idle_kind = KIND_COMMA;   idle_len = 1'b1; end
          default: begin
            idle_valid = 1'b1;
          end
        endcase
      end
    end
  end

  assign position_next = (ch == 8'd0) ? '0 : position + 1'b1;

  assign start_ext = PEXT'(token_start);
  assign pos_ext = PEXT'(position);
  assign pend_len_ext = LEXT'(pend_len);

  always_comb begin
    pend_tok.kind = pend_kind;
    pend_tok.start_offset = start_ext[OFFSET_BITS-1:0];
    pend_tok.text_length = pend_len_ext[TLEN_BITS-1:0];
    idle_tok.kind = idle_kind;
    idle_tok.start_offset = pos_ext[OFFSET_BITS-1:0];
    idle_tok.text_length = TLEN_BITS'(idle_len);
    entry.pair = pend_valid && idle_valid;
    entry.first = pend_valid ? pend_tok : idle_tok;
    entry.second = idle_tok;
  end

  assign entry_valid = pend_valid || idle_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      position <= '0;
      token_start <= '0;
      token_length <= '0;
      word_prefix <= '0;
    end else if (accept) begin
      mode <= mode_next;
      position <= position_next;
      token_start <= token_start_next;
      token_length <= token_length_next;
      word_prefix <= word_prefix_next;
    end
  end

endmodule

FILE: hdl/stok_queue.sv
// Short queue of per-byte result groups between the tokenizer front and back ends.
// Depends on stok_pkg.
module stok_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  stok_pkg::entry_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output stok_pkg::entry_t rd_data,
  output logic             empty
);
  import stok_pkg::*;

  entry_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full = (count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/stok_back.sv
// Back end of the source tokenizer: splits result groups into single results
// and holds the output register. Depends on stok_pkg.
module stok_back (
  input  logic             clk,
  input  logic             rst,
  input  stok_pkg::entry_t head,
  input  logic             head_valid,
  output logic             head_pop,
  output logic [5:0]       kind,
  output logic [31:0]      start_offset,
  output logic [15:0]      text_length,
  output logic             last,
  output logic             empty,
  input  logic             pop
);
  import stok_pkg::*;

  logic out_valid;
  logic half;
  tok_t out_tok;
  logic out_last;
  logic load;
  tok_t sel_tok;
  logic sel_last;

  assign load = head_valid && (!out_valid || pop);
  assign sel_tok = half ? head.second : head.first;
  assign sel_last = !head.pair || half;
  assign head_pop = load && sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      half <= head.pair && !half;
      out_tok <= sel_tok;
      out_last <= sel_last;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign kind = out_tok.kind;
  assign start_offset = out_tok.start_offset;
  assign text_length = out_tok.text_length;
  assign last = out_last;
  assign empty = !out_valid;

endmodule

FILE: hdl/source_tokenizer_core.sv
// Source tokenizer top level: front end, result queue and back end.
// Takes one byte per cycle while full is low; its results pass the queue and the
// output register. Results leave at one per cycle while pop is held, so a byte
// with two results holds the output twice; the four-entry queue absorbs the gap.
// Synchronous reset clears the lexer mode, position, queue and output register.
module source_tokenizer_core #(
  parameter int POSITION_BITS = stok_pkg::DEF_POSITION_BITS,
  parameter int LENGTH_BITS = stok_pkg::DEF_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        push,
  output logic        full,
  output logic [5:0]  kind,
  output logic [31:0] start_offset,
  output logic [15:0] text_length,
  output logic        last,
  output logic        empty,
  input  logic        pop
);
  import stok_pkg::*;

  logic   accept;
  entry_t front_entry;
  logic   front_valid;
  entry_t head;
  logic   queue_empty;
  logic   head_pop;

  assign accept = push && !full;

  stok_front #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .ch(ch),
    .accept(accept),
    .entry(front_entry),
    .entry_valid(front_valid)
  );

  stok_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(accept && front_valid),
    .wr_data(front_entry),
    .full(full),
    .rd_en(head_pop),
    .rd_data(head),
    .empty(queue_empty)
  );

  stok_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .head_valid(!queue_empty),
    .head_pop(head_pop),
    .kind(kind),
    .start_offset(start_offset),
    .text_length(text_length),
    .last(last),
    .empty(empty),
    .pop(pop)
  );

endmodule

FILE: hdl/stok_checker.sv
// Port-level checks for the source tokenizer, bound to the top level.
// Depends on stok_pkg and source_tokenizer_core_assert.svh.
`include "source_tokenizer_core_assert.svh"

module stok_checker (
  input logic        clk,
  input logic        rst,
  input logic [7:0]  ch,
  input logic        push,
  input logic        full,
  input logic [5:0]  kind,
  input logic [31:0] start_offset,
  input logic [15:0] text_length,
  input logic        last,
  input logic        empty,
  input logic        pop
);
  import stok_pkg::*;

  `STOK_ASSERT_RST(a_reset_clears, rst |=> empty && !full)
  `STOK_ASSERT_ON(a_result_holds, !empty && !pop |=> !empty && $stable(kind) && $stable(start_offset) && $stable(text_length) && $stable(last))
  `STOK_ASSERT_ON(a_end_kind_empty, !empty && kind == KIND_END |-> text_length == 16'd0)
  `STOK_ASSERT_ON(a_pair_op_len, !empty && (kind == KIND_EQEQ || kind == KIND_LE || kind == KIND_GE || kind == KIND_NE || kind == KIND_ANDAND || kind == KIND_OROR) |-> text_length == 16'd2)

endmodule

bind source_tokenizer_core stok_checker u_stok_checker (.*);

FILE: sim/source_tokenizer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for source_tokenizer_core: a directed byte table and random
// sources, all scored against a behavioral lexer.
// Depends on stok_pkg (hdl/stok_pkg.sv) and the source_tokenizer_core RTL.
module source_tokenizer_core_tb;
  import stok_pkg::*;

  localparam logic [7:0] END_BYTE = 8'h00;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 600;
  localparam int ROW_COUNT = 23;

  typedef enum logic [4:0] {
    LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BSTAR, LX_INT, LX_STR, LX_ESC,
    LX_IDENT, LX_EQ, LX_LT, LX_GT, LX_BANG, LX_AMP, LX_BAR
  } lex_mode_e;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] start;
    logic [TLEN_BITS-1:0]   len;
    logic                   last;
  } token_t;

  typedef struct {
    string                text;
    bit                   ends;
    bit                   typed;
    logic [KIND_BITS-1:0] kind;
    logic [31:0]          offset;
    logic [15:0]          length;
  } row_t;

  logic        clk;
  logic        rst;
  logic [7:0]  ch;
  logic        push;
  logic        full;
  logic [5:0]  kind;
  logic [31:0] start_offset;
  logic [15:0] text_length;
  logic        last;
  logic        empty;
  logic        pop;

  token_t    tokens_due[$];
  token_t    byte_tokens[$];
  token_t    armed_tok;
  bit        armed = 1'b0;
  logic [7:0] src_bytes[$];

  lex_mode_e  lx_mode = LX_IDLE;
  logic [DEF_POSITION_BITS-1:0] lx_pos = '0;
  logic [31:0] lx_start = '0;
  logic [15:0] lx_len = '0;
  logic [63:0] lx_prefix = '0;

  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_pending = 1'b0;
  bit  no_idle = 1'b0;

  string kw_words [KW_COUNT] = '{"print", "func", "return", "if", "else", "while", "break",
                                 "continue"};
  logic [KIND_BITS-1:0] kw_kinds [KW_COUNT] = '{KIND_PRINT, KIND_FUNC, KIND_RETURN, KIND_IF,
                                               KIND_ELSE, KIND_WHILE, KIND_BREAK, KIND_CONTINUE};
  string op_texts [23] = '{"+", "-", "*", "/", "%", "==", "=", ";", "(", ")", "{", "}", ",",
                           "<=", "<", ">=", ">", "!=", "!", "&&", "||", "&", "|"};

  row_t dir_rows [ROW_COUNT] = '{
    '{"", 1, 1, KIND_END, 0, 0},
    '{"\377", 0, 1, KIND_END, 0, 0},
    '{"\001", 1, 1, KIND_END, 2, 0},
    '{"+-*%;(){},", 1, 0, KIND_END, 0, 0},
    '{"== = <= < >= > != !x", 1, 0, KIND_END, 0, 0},
    '{"&&||&x|y&|", 1, 0, KIND_END, 0, 0},
    '{"&", 1, 1, KIND_END, 1, 0},
    '{"print func return if else while break", 1, 0, KIND_END, 0, 0},
    '{"continue ", 0, 1, KIND_CONTINUE, 0, 8},
    '{"printx prin _a9 Zz9_", 1, 1, KIND_END, 29, 0},
    '{"0 4294967295 007", 1, 0, KIND_END, 0, 0},
    '{"\"ab\\\"c\" \"\"", 1, 0, KIND_END, 0, 0},
    '{"\"abc", 1, 1, KIND_END, 4, 0},
    '{"\"a\\", 1, 1, KIND_END, 3, 0},
    '{"// line\n7 /* b ** */x/**/", 1, 0, KIND_END, 0, 0},
    '{"/* open", 1, 1, KIND_END, 7, 0},
    '{"// open", 1, 1, KIND_END, 7, 0},
    '{"/*a*", 1, 1, KIND_END, 4, 0},
    '{"/x/", 1, 0, KIND_END, 0, 0},
    '{" \t\n\013\014\015~", 1, 0, KIND_END, 0, 0},
    '{"9", 1, 1, KIND_END, 1, 0},
    '{"\177\200@", 1, 0, KIND_END, 0, 0},
    '{"x=1;y<=2>=3", 1, 0, KIND_END, 0, 0}
  };

  source_tokenizer_core DUT (
    .clk(clk),
    .rst(rst),
    .ch(ch),
    .push(push),
    .full(full),
    .kind(kind),
    .start_offset(start_offset),
    .text_length(text_length),
    .last(last),
    .empty(empty),
    .pop(pop)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void add_token(logic [5:0] k, logic [31:0] s, logic [15:0] n);
    token_t t;
    t = '{k, s, n, 1'b0};
    if (byte_tokens.size() < 2) byte_tokens.push_back(t);
  endfunction

  function automatic void open_token(lex_mode_e m, logic [31:0] p);
    lx_mode = m;
    lx_start = p;
    lx_len = 16'd1;
  endfunction

  function automatic void grow_token();
    if (lx_len != 16'hffff) lx_len = lx_len + 16'd1;
  endfunction

  function automatic logic [5:0] word_kind_of();
    logic [63:0] packed_kw;
    for (int i = 0; i < KW_COUNT; i++) begin
      packed_kw = '0;
      for (int j = 0; j < kw_words[i].len(); j++) packed_kw[8*j +: 8] = kw_words[i][j];
      if (lx_len == kw_words[i].len() && packed_kw == lx_prefix) return kw_kinds[i];
    end
    return KIND_IDENT;
  endfunction

  function automatic void lex_fresh(logic [7:0] c, logic [31:0] p);
    lx_mode = LX_IDLE;
    if (c == END_BYTE) begin
      add_token(KIND_END, p, 0);
    end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      return;
    end else if (is_digit(c)) begin
      open_token(LX_INT, p);
    end else if (is_alpha(c) || c == "_") begin
      open_token(LX_IDENT, p);
      lx_prefix = {56'd0, c};
    end else if (c == "\"") begin
      lx_mode = LX_STR;
      lx_start = p + 1;
      lx_len = '0;
    end else begin
      case (c)
        "/": open_token(LX_SLASH, p);
        "=": open_token(LX_EQ, p);
        "<": open_token(LX_LT, p);
        ">": open_token(LX_GT, p);
        "!": open_token(LX_BANG, p);
        "&": open_token(LX_AMP, p);
        "|": open_token(LX_BAR, p);
        "+": add_token(KIND_PLUS, p, 1);
        "-": add_token(KIND_MINUS, p, 1);
        "*": add_token(KIND_STAR, p, 1);
        "%": add_token(KIND_PERCENT, p, 1);
        ";": add_token(KIND_SEMI, p, 1);
        "(": add_token(KIND_LPAREN, p, 1);
        ")": add_token(KIND_RPAREN, p, 1);
        "{": add_token(KIND_LBRACE, p, 1);
        "}": add_token(KIND_RBRACE, p, 1);
        ",": add_token(KIND_COMMA, p, 1);
        default: add_token(KIND_END, p, 0);
      endcase
    end
  endfunction

  function automatic void pair_op(logic [7:0] c, logic [7:0] want, logic [5:0] two,
                                  logic [5:0] one, logic [31:0] p);
    if (c == want) begin
      add_token(two, lx_start, 2);
      lx_mode = LX_IDLE;
    end else begin
      add_token(one, lx_start, (one == KIND_END) ? 16'd0 : 16'd1);
      lex_fresh(c, p);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    logic [31:0] p;
    token_t t;
    p = lx_pos;
    byte_tokens.delete();
    case (lx_mode)
      LX_SLASH: begin
        if (c == "/") lx_mode = LX_LINE;
        else if (c == "*") lx_mode = LX_BLOCK;
        else begin
          add_token(KIND_SLASH, lx_start, 1);
          lex_fresh(c, p);
        end
      end
      LX_LINE: begin
        if (c == END_BYTE) lex_fresh(c, p);
        else if (c == "\n") lx_mode = LX_IDLE;
      end
      LX_BLOCK: begin
        if (c == END_BYTE) lex_fresh(c, p);
        else if (c == "*") lx_mode = LX_BSTAR;
      end
      LX_BSTAR: begin
        if (c == END_BYTE) lex_fresh(c, p);
        else if (c == "/") lx_mode = LX_IDLE;
        else if (c != "*") lx_mode = LX_BLOCK;
      end
      LX_INT: begin
        if (is_digit(c)) grow_token();
        else begin
          add_token(KIND_INT, lx_start, lx_len);
          lex_fresh(c, p);
        end
      end
      LX_STR, LX_ESC: begin
        if (c == END_BYTE) begin
          add_token(KIND_STRING, lx_start, lx_len);
          lex_fresh(c, p);
        end else if (lx_mode == LX_ESC) begin
          grow_token();
          lx_mode = LX_STR;
        end else if (c == "\"") begin
          add_token(KIND_STRING, lx_start, lx_len);
          lx_mode = LX_IDLE;
        end else begin
          if (c == "\\") lx_mode = LX_ESC;
          grow_token();
        end
      end
      LX_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          if (lx_len < 16'd8) lx_prefix[8*lx_len +: 8] = c;
          grow_token();
        end else begin
          add_token(word_kind_of(), lx_start, lx_len);
          lex_fresh(c, p);
        end
      end
      LX_EQ: pair_op(c, "=", KIND_EQEQ, KIND_ASSIGN, p);
      LX_LT: pair_op(c, "=", KIND_LE, KIND_LT, p);
      LX_GT: pair_op(c, "=", KIND_GE, KIND_GT, p);
      LX_BANG: pair_op(c, "=", KIND_NE, KIND_BANG, p);
      LX_AMP: pair_op(c, "&", KIND_ANDAND, KIND_END, p);
      LX_BAR: pair_op(c, "|", KIND_OROR, KIND_END, p);
      default: lex_fresh(c, p);
    endcase
    lx_pos = (c == END_BYTE) ? '0 : p + 1;
    if (byte_tokens.size() > 0) begin
      t = byte_tokens.pop_back();
      t.last = 1'b1;
      byte_tokens.push_back(t);
    end
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (pop && !empty) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected transaction kind %0d offset %0d length %0d last %0d",
                   $time, kind, start_offset, text_length, last);
          errors++;
        end else begin
          want = tokens_due.pop_front();
          check_field("kind", want.kind, kind);
          check_field("start_offset", want.start, start_offset);
          check_field("text_length", want.len, text_length);
          check_field("last", want.last, last);
        end
      end
      if (push && !full) begin
        lex_byte(ch);
        if (armed && byte_tokens.size() > 0) begin
          void'(byte_tokens.pop_back());
          byte_tokens.push_back(armed_tok);
        end
        armed = 1'b0;
        foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
      end
      idle_cycles <= ((pop && !empty) || (push && !full)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("source_tokenizer_core regression: fail");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int gap_left;
    gap_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (gap_left > 0 && !no_idle) begin
        pop <= 1'b0;
        gap_left--;
      end else begin
        pop <= 1'b1;
        gap_left = idle_len();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    ch <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void arm_check(logic [5:0] k, logic [31:0] s, logic [15:0] n);
    armed_tok = '{k, s, n, 1'b1};
    armed = 1'b1;
  endfunction

  function automatic logic [7:0] rand_word_char(bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return "a" + r;
    if (r < 52) return "A" + (r - 26);
    if (r == 52) return "_";
    return "0" + (r - 53);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_printable();
    return $urandom_range(32, 126);
  endfunction

  function automatic void add_fragment();
    int pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      src_bytes.push_back(rand_word_char(1));
      repeat ($urandom_range(0, 11)) src_bytes.push_back(rand_word_char(0));
    end else if (pick < 30) begin
      put_text(kw_words[$urandom_range(0, KW_COUNT - 1)]);
      if ($urandom_range(0, 4) == 0) src_bytes.push_back(rand_word_char(0));
    end else if (pick < 42) begin
      repeat ($urandom_range(1, 10)) src_bytes.push_back("0" + $urandom_range(0, 9));
    end else if (pick < 52) begin
      src_bytes.push_back("\"");
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          src_bytes.push_back("\\");
          src_bytes.push_back($urandom_range(1, 255));
        end else begin
          c = rand_printable();
          if (c == "\"" || c == "\\") c = "x";
          src_bytes.push_back(c);
        end
      end
      if ($urandom_range(0, 9) != 0) src_bytes.push_back("\"");
    end else if (pick < 74) begin
      put_text(op_texts[$urandom_range(0, 22)]);
    end else if (pick < 82) begin
      c = $urandom_range(9, 14);
      src_bytes.push_back((c == 8'd14) ? " " : c);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 0) begin
        put_text("//");
        repeat ($urandom_range(0, 10)) src_bytes.push_back(rand_printable());
        if ($urandom_range(0, 9) != 0) src_bytes.push_back("\n");
      end else begin
        put_text("/*");
        repeat ($urandom_range(0, 10))
          src_bytes.push_back(($urandom_range(0, 2) == 0) ? "*" : rand_printable());
        if ($urandom_range(0, 9) != 0) put_text("*/");
      end
    end else begin
      src_bytes.push_back($urandom_range(0, 255));
    end
    if ($urandom_range(0, 2) != 0) src_bytes.push_back(" ");
  endfunction

  initial begin
    int n;
    int sent;
    int src_count;
    rst = 1'b1;
    push = 1'b0;
    ch = END_BYTE;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      n = dir_rows[r].text.len();
      for (int i = 0; i < n; i++) begin
        if (dir_rows[r].typed && !dir_rows[r].ends && i == n - 1)
          arm_check(dir_rows[r].kind, dir_rows[r].offset, dir_rows[r].length);
        send_byte(dir_rows[r].text[i]);
      end
      if (dir_rows[r].ends) begin
        if (dir_rows[r].typed)
          arm_check(dir_rows[r].kind, dir_rows[r].offset, dir_rows[r].length);
        send_byte(END_BYTE);
      end
    end

    sent = 0;
    src_count = 0;
    while (sent < RANDOM_ITEMS) begin
      src_bytes.delete();
      repeat ($urandom_range(3, 25)) add_fragment();
      src_bytes.push_back(END_BYTE);
      if (src_count == 3 || src_count == 20) hold_pending = 1'b1;
      if (src_count == 8) begin
        push <= 1'b0;
        do @(negedge clk); while (tokens_due.size() != 0);
      end
      no_idle = (src_count >= 12 && src_count < 16);
      foreach (src_bytes[i]) send_byte(src_bytes[i]);
      sent += src_bytes.size();
      src_count++;
    end
    no_idle = 1'b0;
    push <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("source_tokenizer_core regression: pass");
    end else begin
      $display("source_tokenizer_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/stok_pkg.sv
hdl/stok_front.sv
hdl/stok_queue.sv
hdl/stok_back.sv
hdl/source_tokenizer_core.sv
hdl/stok_checker.sv
sim/source_tokenizer_core_tb.sv
